@@ design/gsp_pkg.sv @@
// Shared types, constants and helpers of the grid safest path search.
package gsp_pkg;

  localparam int GRID_SIDE = 32;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int N_W       = IDX_W + 1;
  localparam int MAX_PATH  = 64;
  localparam int CNT_W     = $clog2(MAX_PATH) + 1;
  localparam int DANGER_W  = 24;
  localparam int COST_W    = 16;
  localparam int SIDE_W    = 6;
  localparam int TAG_W     = 6;
  localparam int LINK_W    = 3;
  localparam int STATUS_W  = 2;

  localparam logic [DANGER_W-1:0] DANGER_MAX = '1;
  localparam logic [TAG_W-1:0]    TAG_NONE   = '1;

  // Link codes name where the parent lies; a child link uses the same code
  // with the step reversed.
  localparam logic [LINK_W-1:0] LINK_NONE  = 3'd0;
  localparam logic [LINK_W-1:0] LINK_LEFT  = 3'd1;
  localparam logic [LINK_W-1:0] LINK_RIGHT = 3'd2;
  localparam logic [LINK_W-1:0] LINK_UP    = 3'd3;
  localparam logic [LINK_W-1:0] LINK_DOWN  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_DEST = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_LVL_START,
    S_P_RD,
    S_P_CHK,
    S_N_SEL,
    S_N_UPD,
    S_LVL_END,
    S_WALK_RD,
    S_WALK_CHK,
    S_OUT_RD,
    S_OUT_EMIT,
    S_NO_DEST
  } state_e;

  // One cell of the search state memory.
  typedef struct packed {
    logic [LINK_W-1:0]   child;
    logic [TAG_W-1:0]    tag_o;
    logic [TAG_W-1:0]    tag_e;
    logic [LINK_W-1:0]   parent;
    logic [DANGER_W-1:0] danger;
  } cell_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(GRID_SIDE)) begin
      r = SIDE_W'(GRID_SIDE);
    end
    return r;
  endfunction

endpackage

@@ design/grid_safest_path_search.sv @@
// Depth-limited least-danger path search over a 32x32 cost grid. A load word
// writes one cell cost. A search word first clears all 1024 cells of the search
// state memory and seeds the origin, then runs up to depth_limit levels. Each
// level scans the grid in use row-major. Each frontier tile reads each of its
// neighbors inside the grid in turn, since every access goes through the one
// read port of the state memory. The parent chain is then walked back and
// replayed from the origin as result words, at most 64 of them, the last one
// flagged. A search whose origin lies outside the grid in use, or whose depth
// limit is zero, gives its single result word without any of this. The input
// is taken only while no search is running; the output register lets the
// block accept a new word while the final result of a search still waits.
module grid_safest_path_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [4:0]  cell_x_i,
  input  logic [4:0]  cell_y_i,
  input  logic [15:0] cell_cost_i,
  input  logic [4:0]  start_x_i,
  input  logic [4:0]  start_y_i,
  input  logic [5:0]  depth_limit_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  path_x_o,
  output logic [4:0]  path_y_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int IW = gsp_pkg::IDX_W;
  localparam int CW = gsp_pkg::COORD_W;
  localparam int DW = gsp_pkg::DANGER_W;
  localparam int SW = gsp_pkg::SIDE_W;
  localparam int TW = gsp_pkg::TAG_W;
  localparam int LW = gsp_pkg::LINK_W;
  localparam int NW = gsp_pkg::N_W;
  localparam int KW = gsp_pkg::CNT_W;
  localparam logic [IW-1:0] ROW_STEP = IW'(gsp_pkg::GRID_SIDE);

  // Configuration registers.
  logic [SW-1:0] grid_width_q, grid_height_q;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= SW'(gsp_pkg::GRID_SIDE);
      grid_height_q <= SW'(gsp_pkg::GRID_SIDE);
    end else if (cfg_we) begin
      if (paddr[2] == gsp_pkg::REG_GRID_WIDTH) begin
        grid_width_q <= pwdata[SW-1:0];
      end else begin
        grid_height_q <= pwdata[SW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == gsp_pkg::REG_GRID_WIDTH) ? 32'(grid_width_q)
                                                          : 32'(grid_height_q);

  // Control and datapath registers.
  gsp_pkg::state_e state_q, state_d;
  logic [CW-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic [SW-1:0]   depth_q, depth_d, w_q, w_d, h_q, h_d;
  logic [TW-1:0]   level_q, level_d;
  logic [CW-1:0]   px_q, px_d, py_q, py_d;
  logic [1:0]      dir_q, dir_d;
  logic [DW-1:0]   dp_q, dp_d;
  logic            found_q, found_d, any_q, any_d, dest_q, dest_d;
  logic [IW-1:0]   best_tile_q, best_tile_d;
  logic [DW-1:0]   best_dgr_q, best_dgr_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic [IW-1:0]   v_q, v_d;
  logic [LW-1:0]   code_q, code_d;
  logic [IW-1:0]   cur_q, cur_d;
  logic [LW-1:0]   pend_q, pend_d;
  logic [NW-1:0]   n_q, n_d;
  logic [KW-1:0]   cnt_q, cnt_d, k_q, k_d;
  logic            trunc_q, trunc_d;
  logic            out_valid_q, out_valid_d;
  logic [CW-1:0]   out_x_q, out_x_d, out_y_q, out_y_d;
  logic [1:0]      out_st_q, out_st_d;
  logic            out_last_q, out_last_d;

  // Memories.
  logic                       st_we, cost_we;
  logic [IW-1:0]              st_waddr, rd_addr, cost_waddr;
  gsp_pkg::cell_t             st_wdata, st_rdata;
  logic [gsp_pkg::COST_W-1:0] cost_rdata;

  gsp_ram #(.WIDTH($bits(gsp_pkg::cell_t)), .DEPTH(gsp_pkg::CELLS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (rd_addr),
    .rdata_o (st_rdata)
  );

  gsp_ram #(.WIDTH(gsp_pkg::COST_W), .DEPTH(gsp_pkg::CELLS)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (cost_waddr),
    .wdata_i (cell_cost_i),
    .raddr_i (rd_addr),
    .rdata_o (cost_rdata)
  );

  assign cost_waddr = {cell_y_i, cell_x_i};

  // Helpers shared by the state machine.
  logic [IW-1:0]   p_idx, origin, nb_idx;
  logic            nb_ok, p_last_x, p_last_y, slot_free;
  logic [LW-1:0]   nb_code;
  logic [TW-1:0]   lvl_prev;
  logic [TW-1:0]   prev_tag;
  logic [DW:0]     sum;
  logic [DW-1:0]   nd;
  logic            upd;
  logic [NW-1:0]   n_inc;
  logic [CW-1:0]   cur_x, cur_y;

  assign p_idx     = {py_q, px_q};
  assign origin    = {sy_q, sx_q};
  assign p_last_x  = ({1'b0, px_q} + SW'(1)) == w_q;
  assign p_last_y  = ({1'b0, py_q} + SW'(1)) == h_q;
  assign lvl_prev  = level_q - TW'(1);
  assign prev_tag  = lvl_prev[0] ? st_rdata.tag_o : st_rdata.tag_e;
  assign sum       = {1'b0, dp_q} + (DW + 1)'(cost_rdata);
  assign nd        = sum[DW] ? gsp_pkg::DANGER_MAX : sum[DW-1:0];
  assign upd       = (v_q != origin) && ((st_rdata.danger == '0) || (nd < st_rdata.danger));
  assign n_inc     = n_q + NW'(1);
  assign cur_x     = cur_q[CW-1:0];
  assign cur_y     = cur_q[IW-1:CW];
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    nb_ok   = 1'b0;
    nb_idx  = p_idx;
    nb_code = gsp_pkg::LINK_NONE;
    case (dir_q)
      2'd0: begin
        nb_ok   = px_q != '0;
        nb_idx  = p_idx - IW'(1);
        nb_code = gsp_pkg::LINK_RIGHT;
      end
      2'd1: begin
        nb_ok   = !p_last_x;
        nb_idx  = p_idx + IW'(1);
        nb_code = gsp_pkg::LINK_LEFT;
      end
      2'd2: begin
        nb_ok   = py_q != '0;
        nb_idx  = p_idx - ROW_STEP;
        nb_code = gsp_pkg::LINK_DOWN;
      end
      default: begin
        nb_ok   = !p_last_y;
        nb_idx  = p_idx + ROW_STEP;
        nb_code = gsp_pkg::LINK_UP;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    depth_d     = depth_q;
    w_d         = w_q;
    h_d         = h_q;
    level_d     = level_q;
    px_d        = px_q;
    py_d        = py_q;
    dir_d       = dir_q;
    dp_d        = dp_q;
    found_d     = found_q;
    any_d       = any_q;
    dest_d      = dest_q;
    best_tile_d = best_tile_q;
    best_dgr_d  = best_dgr_q;
    clr_d       = clr_q;
    v_d         = v_q;
    code_d      = code_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    trunc_d     = trunc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_st_d    = out_st_q;
    out_last_d  = out_last_q;
    in_ready_o  = 1'b0;
    cost_we     = 1'b0;
    st_we       = 1'b0;
    st_waddr    = clr_q;
    st_wdata    = '{child: gsp_pkg::LINK_NONE, tag_o: gsp_pkg::TAG_NONE,
                    tag_e: gsp_pkg::TAG_NONE, parent: gsp_pkg::LINK_NONE, danger: '0};
    rd_addr     = cur_q;

    case (state_q)
      gsp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (gsp_pkg::opcode_e'(opcode_i) == gsp_pkg::OP_LOAD) begin
            cost_we = 1'b1;
          end else begin
            sx_d    = start_x_i;
            sy_d    = start_y_i;
            depth_d = depth_limit_i;
            w_d     = gsp_pkg::clamp_side(grid_width_q);
            h_d     = gsp_pkg::clamp_side(grid_height_q);
            dest_d  = 1'b0;
            clr_d   = '0;
            if ((SW'(start_x_i) >= gsp_pkg::clamp_side(grid_width_q)) ||
                (SW'(start_y_i) >= gsp_pkg::clamp_side(grid_height_q)) ||
                (depth_limit_i == '0)) begin
              state_d = gsp_pkg::S_NO_DEST;
            end else begin
              state_d = gsp_pkg::S_CLEAR;
            end
          end
        end
      end

      gsp_pkg::S_CLEAR: begin
        st_we = 1'b1;
        clr_d = clr_q + IW'(1);
        if (&clr_q) begin
          state_d = gsp_pkg::S_SEED;
        end
      end

      gsp_pkg::S_SEED: begin
        st_we          = 1'b1;
        st_waddr       = origin;
        st_wdata.tag_e = '0;
        level_d        = TW'(1);
        state_d        = gsp_pkg::S_LVL_START;
      end

      gsp_pkg::S_LVL_START: begin
        found_d = 1'b0;
        any_d   = 1'b0;
        px_d    = '0;
        py_d    = '0;
        state_d = gsp_pkg::S_P_RD;
      end

      gsp_pkg::S_P_RD: begin
        rd_addr = p_idx;
        state_d = gsp_pkg::S_P_CHK;
      end

      gsp_pkg::S_P_CHK: begin
        if (prev_tag == lvl_prev) begin
          dp_d    = st_rdata.danger;
          dir_d   = 2'd0;
          state_d = gsp_pkg::S_N_SEL;
        end else if (p_last_x && p_last_y) begin
          state_d = gsp_pkg::S_LVL_END;
        end else begin
          px_d    = p_last_x ? '0 : px_q + CW'(1);
          py_d    = p_last_x ? py_q + CW'(1) : py_q;
          state_d = gsp_pkg::S_P_RD;
        end
      end

      gsp_pkg::S_N_SEL, gsp_pkg::S_N_UPD: begin
        rd_addr = nb_idx;
        if (state_q == gsp_pkg::S_N_SEL && nb_ok) begin
          v_d     = nb_idx;
          code_d  = nb_code;
          state_d = gsp_pkg::S_N_UPD;
        end else begin
          if (state_q == gsp_pkg::S_N_UPD && upd) begin
            st_we           = 1'b1;
            st_waddr        = v_q;
            st_wdata        = st_rdata;
            st_wdata.danger = nd;
            st_wdata.parent = code_q;
            if (level_q[0]) begin
              st_wdata.tag_o = level_q;
            end else begin
              st_wdata.tag_e = level_q;
            end
            any_d = 1'b1;
            if (!found_q || nd < best_dgr_q) begin
              best_tile_d = v_q;
              best_dgr_d  = nd;
              found_d     = 1'b1;
              dest_d      = 1'b1;
            end
          end
          // Move on to the next neighbor, to the next cell of the scan, or to the end of the level.
          if (dir_q != 2'd3) begin
            dir_d   = dir_q + 2'd1;
            state_d = gsp_pkg::S_N_SEL;
          end else if (p_last_x && p_last_y) begin
            state_d = gsp_pkg::S_LVL_END;
          end else begin
            px_d    = p_last_x ? '0 : px_q + CW'(1);
            py_d    = p_last_x ? py_q + CW'(1) : py_q;
            state_d = gsp_pkg::S_P_RD;
          end
        end
      end

      gsp_pkg::S_LVL_END: begin
        if (any_q && (SW'(level_q) < depth_q)) begin
          level_d = level_q + TW'(1);
          state_d = gsp_pkg::S_LVL_START;
        end else if (dest_q) begin
          cur_d   = best_tile_q;
          pend_d  = gsp_pkg::LINK_NONE;
          n_d     = '0;
          state_d = gsp_pkg::S_WALK_RD;
        end else begin
          state_d = gsp_pkg::S_NO_DEST;
        end
      end

      gsp_pkg::S_WALK_RD: begin
        state_d = gsp_pkg::S_WALK_CHK;
      end

      gsp_pkg::S_WALK_CHK: begin
        // Leave a forward link in each tile so the path can be replayed from
        // the origin.
        st_we          = 1'b1;
        st_waddr       = cur_q;
        st_wdata       = st_rdata;
        st_wdata.child = pend_q;
        n_d            = n_inc;
        pend_d         = st_rdata.parent;
        state_d        = gsp_pkg::S_WALK_RD;
        case (st_rdata.parent)
          gsp_pkg::LINK_NONE: begin
            trunc_d = n_inc > NW'(gsp_pkg::MAX_PATH);
            cnt_d   = (n_inc > NW'(gsp_pkg::MAX_PATH)) ? KW'(gsp_pkg::MAX_PATH)
                                                       : n_inc[KW-1:0];
            k_d     = '0;
            cur_d   = origin;
            state_d = gsp_pkg::S_OUT_RD;
          end
          gsp_pkg::LINK_LEFT: begin
            cur_d = cur_q - IW'(1);
            if (cur_x == '0) state_d = gsp_pkg::S_NO_DEST;
          end
          gsp_pkg::LINK_RIGHT: begin
            cur_d = cur_q + IW'(1);
            if (&cur_x) state_d = gsp_pkg::S_NO_DEST;
          end
          gsp_pkg::LINK_UP: begin
            cur_d = cur_q - ROW_STEP;
            if (cur_y == '0) state_d = gsp_pkg::S_NO_DEST;
          end
          gsp_pkg::LINK_DOWN: begin
            cur_d = cur_q + ROW_STEP;
            if (&cur_y) state_d = gsp_pkg::S_NO_DEST;
          end
          default: begin
            state_d = gsp_pkg::S_NO_DEST;
          end
        endcase
        // A walk that has not met the origin after every cell is a loop.
        if (st_rdata.parent != gsp_pkg::LINK_NONE &&
            n_inc == NW'(gsp_pkg::CELLS)) begin
          state_d = gsp_pkg::S_NO_DEST;
        end
      end

      gsp_pkg::S_OUT_RD: begin
        state_d = gsp_pkg::S_OUT_EMIT;
      end

      gsp_pkg::S_OUT_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_x_d     = cur_x;
          out_y_d     = cur_y;
          out_st_d    = trunc_q ? gsp_pkg::ST_TRUNC : gsp_pkg::ST_OK;
          out_last_d  = (k_q + KW'(1)) == cnt_q;
          k_d         = k_q + KW'(1);
          if ((k_q + KW'(1)) == cnt_q) begin
            state_d = gsp_pkg::S_IDLE;
          end else begin
            case (st_rdata.child)
              gsp_pkg::LINK_LEFT:  cur_d = cur_q + IW'(1);
              gsp_pkg::LINK_RIGHT: cur_d = cur_q - IW'(1);
              gsp_pkg::LINK_UP:    cur_d = cur_q + ROW_STEP;
              gsp_pkg::LINK_DOWN:  cur_d = cur_q - ROW_STEP;
              default:             cur_d = cur_q;
            endcase
            state_d = gsp_pkg::S_OUT_RD;
          end
        end
      end

      gsp_pkg::S_NO_DEST: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_x_d     = sx_q;
          out_y_d     = sy_q;
          out_st_d    = gsp_pkg::ST_NO_DEST;
          out_last_d  = 1'b1;
          state_d     = gsp_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = gsp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      any_q       <= 1'b0;
      dest_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      any_q       <= any_d;
      dest_q      <= dest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    depth_q     <= depth_d;
    w_q         <= w_d;
    h_q         <= h_d;
    level_q     <= level_d;
    px_q        <= px_d;
    py_q        <= py_d;
    dir_q       <= dir_d;
    dp_q        <= dp_d;
    best_tile_q <= best_tile_d;
    best_dgr_q  <= best_dgr_d;
    clr_q       <= clr_d;
    v_q         <= v_d;
    code_q      <= code_d;
    cur_q       <= cur_d;
    pend_q      <= pend_d;
    n_q         <= n_d;
    cnt_q       <= cnt_d;
    k_q         <= k_d;
    trunc_q     <= trunc_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_st_q    <= out_st_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign path_x_o    = out_x_q;
  assign path_y_o    = out_y_q;
  assign status_o    = out_st_q;
  assign last_o      = out_last_q;

endmodule

@@ design/gsp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module gsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
